/* design/srm_pkg.sv */
package srm_pkg;

  // Field widths of one tick beat and one result beat.
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 16;

  // Command codes carried in the opcode field.
  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_READ  = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_TICKS    = 1'b1;
  localparam logic [ByteW-1:0] DEV_ADDR_RST = 8'h42;
  localparam logic [ByteW-1:0] TICKS_RST    = 8'd2;

  typedef struct packed {
    logic [ByteW-1:0] dev_addr;
    logic [ByteW-1:0] ticks;
  } cfg_t;

  typedef struct packed {
    logic             sda_in;
    logic [ByteW-1:0] write_data;
    logic [ByteW-1:0] reg_addr;
    logic [OpW-1:0]   opcode;
  } tick_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             success;
    logic             done_res;
    logic             busy_res;
    logic             sda_drive;
    logic             sda_out;
    logic             scl;
  } res_t;

endpackage

/* design/srm_cfg_regs.sv */
module srm_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output srm_pkg::cfg_t        cfg_o
);
  import srm_pkg::*;

  logic [ByteW-1:0] dev_addr_q;
  logic [ByteW-1:0] ticks_q;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register file, written in the access cycle of a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
      ticks_q    <= TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEV_ADDR: dev_addr_q <= pwdata[ByteW-1:0];
        REG_TICKS:    ticks_q    <= pwdata[ByteW-1:0];
        default:      ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      REG_DEV_ADDR: prdata = {24'd0, dev_addr_q};
      REG_TICKS:    prdata = {24'd0, ticks_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o.dev_addr = dev_addr_q;
  assign cfg_o.ticks    = ticks_q;

endmodule

/* design/srm_seq.sv */
module srm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  srm_pkg::tick_t item_i,
  input  srm_pkg::cfg_t  cfg_i,
  output srm_pkg::res_t  res_o
);
  import srm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
    PH_WB_SET, PH_WB_HI, PH_WB_LO,
    PH_ACK_REL, PH_ACK_HI, PH_ACK_SMP, PH_ACK_LO,
    PH_SP_A, PH_SP_B, PH_SP_C,
    PH_RB_HI, PH_RB_SMP, PH_RB_LO,
    PH_NA_A, PH_NA_B, PH_NA_C, PH_NA_D
  } phase_e;

  typedef enum logic [3:0] {
    SEG_START, SEG_WADDR, SEG_WREG, SEG_WDATA, SEG_RADDR,
    SEG_ACK, SEG_STOP, SEG_RBYTE, SEG_NACK, SEG_END
  } seg_e;

  localparam logic [3:0] LastStage = 4'd12;
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Segment script for a register write (rm = 0) and a register read (rm = 1).
  function automatic seg_e script_seg(input logic rm, input logic [3:0] idx);
    seg_e s;
    s = SEG_END;
    if (!rm) begin
      case (idx)
        4'd0: s = SEG_START;
        4'd1: s = SEG_WADDR;
        4'd2: s = SEG_ACK;
        4'd3: s = SEG_WREG;
        4'd4: s = SEG_ACK;
        4'd5: s = SEG_WDATA;
        4'd6: s = SEG_ACK;
        4'd7: s = SEG_STOP;
        default: s = SEG_END;
      endcase
    end else begin
      case (idx)
        4'd0:  s = SEG_START;
        4'd1:  s = SEG_WADDR;
        4'd2:  s = SEG_ACK;
        4'd3:  s = SEG_WREG;
        4'd4:  s = SEG_ACK;
        4'd5:  s = SEG_STOP;
        4'd6:  s = SEG_START;
        4'd7:  s = SEG_RADDR;
        4'd8:  s = SEG_ACK;
        4'd9:  s = SEG_RBYTE;
        4'd10: s = SEG_NACK;
        4'd11: s = SEG_STOP;
        default: s = SEG_END;
      endcase
    end
    return s;
  endfunction

  phase_e           phase_q, phase_d, enter_ph;
  seg_e             seg;
  logic [ByteW-1:0] cnt_q, cnt_d, cnt_inc, hold;
  logic [3:0]       bit_q, bit_d;
  logic [3:0]       stage_q, stage_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ByteW-1:0] hreg_q, hreg_d;
  logic [ByteW-1:0] hdata_q, hdata_d;
  logic [ByteW-1:0] rbyte_q, rbyte_d;
  logic             rmode_q, rmode_d;
  logic             failed_q, failed_d;
  logic             scl_q, scl_d, sdo_q, sdo_d, drv_q, drv_d;
  logic             do_enter, do_next, do_seg, ended;
  logic             is_start;

  assign is_start = (item_i.opcode == OP_WRITE) || (item_i.opcode == OP_READ);
  assign hold     = (cfg_i.ticks == '0) ? 8'd1 : cfg_i.ticks;
  assign cnt_inc  = cnt_q + 8'd1;

  // One tick of the sequencer: advance the phase, then open the next segment
  // if the phase chain asks for it, then apply the line effects of the phase entered.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    stage_d  = stage_q;
    shift_d  = shift_q;
    hreg_d   = hreg_q;
    hdata_d  = hdata_q;
    rbyte_d  = rbyte_q;
    rmode_d  = rmode_q;
    failed_d = failed_q;
    scl_d    = scl_q;
    sdo_d    = sdo_q;
    drv_d    = drv_q;
    do_enter = 1'b0;
    do_next  = 1'b0;
    do_seg   = 1'b0;
    enter_ph = PH_IDLE;
    seg      = SEG_END;
    ended    = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (is_start) begin
        hreg_d   = item_i.reg_addr;
        hdata_d  = item_i.write_data;
        rmode_d  = (item_i.opcode == OP_READ);
        failed_d = 1'b0;
        stage_d  = 4'd0;
        do_seg   = 1'b1;
        seg      = SEG_START;
      end
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= hold) begin
        unique case (phase_q)
          PH_ST_A:    begin do_enter = 1'b1; enter_ph = PH_ST_B;    end
          PH_ST_B:    begin do_enter = 1'b1; enter_ph = PH_ST_C;    end
          PH_ST_C:    begin do_enter = 1'b1; enter_ph = PH_ST_D;    end
          PH_WB_SET:  begin do_enter = 1'b1; enter_ph = PH_WB_HI;   end
          PH_WB_HI:   begin do_enter = 1'b1; enter_ph = PH_WB_LO;   end
          PH_ACK_REL: begin do_enter = 1'b1; enter_ph = PH_ACK_HI;  end
          PH_ACK_HI:  begin do_enter = 1'b1; enter_ph = PH_ACK_SMP; end
          PH_ACK_SMP: begin do_enter = 1'b1; enter_ph = PH_ACK_LO;  end
          PH_SP_A:    begin do_enter = 1'b1; enter_ph = PH_SP_B;    end
          PH_SP_B:    begin do_enter = 1'b1; enter_ph = PH_SP_C;    end
          PH_RB_HI:   begin do_enter = 1'b1; enter_ph = PH_RB_SMP;  end
          PH_RB_SMP:  begin do_enter = 1'b1; enter_ph = PH_RB_LO;   end
          PH_NA_A:    begin do_enter = 1'b1; enter_ph = PH_NA_B;    end
          PH_NA_B:    begin do_enter = 1'b1; enter_ph = PH_NA_C;    end
          PH_NA_C:    begin do_enter = 1'b1; enter_ph = PH_NA_D;    end
          PH_ST_D, PH_NA_D: do_next = 1'b1;
          PH_WB_LO, PH_RB_LO: begin
            bit_d = bit_q + 4'd1;
            if (bit_d < BitsPerByte) begin
              do_enter = 1'b1;
              enter_ph = (phase_q == PH_WB_LO) ? PH_WB_SET : PH_RB_HI;
            end else begin
              drv_d   = 1'b1;
              sdo_d   = 1'b0;
              do_next = 1'b1;
            end
          end
          PH_ACK_LO: begin
            drv_d = 1'b1;
            sdo_d = 1'b0;
            if (failed_q) begin
              do_seg = 1'b1;
              seg    = SEG_STOP;
            end else begin
              do_next = 1'b1;
            end
          end
          PH_SP_C: begin
            if (failed_q) begin
              do_seg = 1'b1;
              seg    = SEG_END;
            end else begin
              do_next = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        endcase
      end
    end

    // Step the script to the next segment.
    if (do_next) begin
      do_seg = 1'b1;
      if (stage_q < LastStage) begin
        stage_d = stage_q + 4'd1;
        seg     = script_seg(rmode_d, stage_d);
      end else begin
        seg = SEG_END;
      end
    end

    // Open a segment: load its byte if it has one and pick its first phase, or end the transaction.
    if (do_seg) begin
      bit_d = '0;
      unique case (seg)
        SEG_START: begin do_enter = 1'b1; enter_ph = PH_ST_A; end
        SEG_WADDR: begin shift_d = cfg_i.dev_addr; do_enter = 1'b1; enter_ph = PH_WB_SET; end
        SEG_WREG:  begin shift_d = hreg_q;  do_enter = 1'b1; enter_ph = PH_WB_SET; end
        SEG_WDATA: begin shift_d = hdata_q; do_enter = 1'b1; enter_ph = PH_WB_SET; end
        SEG_RADDR: begin
          shift_d  = cfg_i.dev_addr + 8'd1;
          do_enter = 1'b1;
          enter_ph = PH_WB_SET;
        end
        SEG_ACK:   begin do_enter = 1'b1; enter_ph = PH_ACK_REL; end
        SEG_STOP:  begin do_enter = 1'b1; enter_ph = PH_SP_A;    end
        SEG_RBYTE: begin shift_d = '0; do_enter = 1'b1; enter_ph = PH_RB_HI; end
        SEG_NACK:  begin do_enter = 1'b1; enter_ph = PH_NA_A;    end
        default: begin
          if (rmode_d && !failed_d) rbyte_d = shift_d;
          phase_d = PH_IDLE;
          cnt_d   = '0;
          ended   = 1'b1;
        end
      endcase
    end

    // Enter a phase: restart the hold count and change the lines or sample the data line.
    if (do_enter) begin
      phase_d = enter_ph;
      cnt_d   = '0;
      unique case (enter_ph)
        PH_ST_A, PH_SP_C, PH_NA_A: begin drv_d = 1'b1; sdo_d = 1'b1; end
        PH_ST_C, PH_SP_A, PH_NA_D: begin drv_d = 1'b1; sdo_d = 1'b0; end
        PH_ST_B, PH_WB_HI, PH_ACK_HI, PH_SP_B, PH_NA_B: scl_d = 1'b1;
        PH_ST_D, PH_WB_LO, PH_ACK_LO, PH_RB_LO, PH_NA_C: scl_d = 1'b0;
        PH_WB_SET: begin
          drv_d = 1'b1;
          sdo_d = shift_d[3'd7 - bit_d[2:0]];
        end
        PH_ACK_REL: begin drv_d = 1'b0; sdo_d = 1'b1; end
        PH_ACK_SMP: if (item_i.sda_in) failed_d = 1'b1;
        PH_RB_HI: begin drv_d = 1'b0; sdo_d = 1'b1; scl_d = 1'b1; end
        PH_RB_SMP: shift_d = {shift_d[ByteW-2:0], item_i.sda_in};
        default: ;
      endcase
    end
  end

  // Sequencer state, updated once per tick beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      bit_q    <= '0;
      stage_q  <= '0;
      shift_q  <= '0;
      hreg_q   <= '0;
      hdata_q  <= '0;
      rbyte_q  <= '0;
      rmode_q  <= 1'b0;
      failed_q <= 1'b0;
      scl_q    <= 1'b1;
      sdo_q    <= 1'b1;
      drv_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      bit_q    <= bit_d;
      stage_q  <= stage_d;
      shift_q  <= shift_d;
      hreg_q   <= hreg_d;
      hdata_q  <= hdata_d;
      rbyte_q  <= rbyte_d;
      rmode_q  <= rmode_d;
      failed_q <= failed_d;
      scl_q    <= scl_d;
      sdo_q    <= sdo_d;
      drv_q    <= drv_d;
    end
  end

  // The result of a tick shows the lines after that tick's update.
  assign res_o.scl       = scl_d;
  assign res_o.sda_out   = sdo_d;
  assign res_o.sda_drive = drv_d;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.done_res  = ended;
  assign res_o.success   = ended & ~failed_d;
  assign res_o.read_data = rbyte_d;

`ifndef ASSERT_OFF
  // The bit counter never runs past one byte.
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BitsPerByte)
    else $error("bit index out of range");

  // The data line is released during a transaction only in acknowledge and read slots.
  a_release_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!drv_q && phase_q != PH_IDLE) |->
      (phase_q == PH_ACK_REL || phase_q == PH_ACK_HI || phase_q == PH_ACK_SMP ||
       phase_q == PH_ACK_LO || phase_q == PH_RB_HI || phase_q == PH_RB_SMP ||
       phase_q == PH_RB_LO))
    else $error("data line released outside a slot");

  // A plain tick while idle leaves the sequencer idle.
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_IDLE && !is_start) |=> (phase_q == PH_IDLE))
    else $error("sequencer left idle without a command");
`endif

endmodule

/* design/sccb_register_master.sv */
// Channel  | Dir | Handshake                    | Contents
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | one bus tick with an optional command
// m_axis   | out | m_axis_tvalid/m_axis_tready  | line levels and status after that tick
// apb      | in  | psel/penable/pwrite/pready   | device address and ticks per phase
//
// Each tick beat yields exactly one result beat; one beat per cycle is sustained while m_axis does not stall.
// A tick passes through an input register, then the sequencer step into the result register.
// The tick step is combinational logic on the sequencer state, so beats follow back to back.
// Reset clears the sequencer to idle with the clock high and the data line released.
// A stall on m_axis holds the result register and backs up into the input register.
module sccb_register_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] opcode, [9:2] reg_addr, [17:10] write_data, [18] sda_in, rest zero
  input  logic [srm_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
  // [5] success, [13:6] read_data, rest zero
  output logic [srm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import srm_pkg::*;

  cfg_t  cfg;
  tick_t in_q;
  res_t  res, out_q;
  logic  in_valid_q, out_valid_q;
  logic  step, s_fire;

  // A buffered tick steps when the result register is free or draining.
  assign step          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | step;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.opcode     <= s_axis_tdata[1:0];
      in_q.reg_addr   <= s_axis_tdata[9:2];
      in_q.write_data <= s_axis_tdata[17:10];
      in_q.sda_in     <= s_axis_tdata[18];
    end
  end

  srm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.read_data, out_q.success, out_q.done_res,
                          out_q.busy_res, out_q.sda_drive, out_q.sda_out, out_q.scl};

`ifndef ASSERT_OFF
  // A finished transaction is never reported as still busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("done reported while busy");

  // Success is only flagged together with done.
  a_success_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.success) |-> out_q.done_res)
    else $error("success without done");

  // A buffered tick that cannot step is kept unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_q)))
    else $error("buffered tick lost");
`endif

endmodule
